/* src/otr_pkg.sv */
// Shared types and constants for the bus temperature reader.
`default_nettype none
package otr_pkg;

	// Bus lines and scratchpad length
	localparam int NumLines        = 8;
	localparam int ScratchpadBytes = 9;

	// Input queue depth between the front and the sequencer
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Bus commands and byte markers
	localparam logic [7:0] CmdSkip    = 8'hcc;
	localparam logic [7:0] CmdConvert = 8'h44;
	localparam logic [7:0] CmdReadPad = 8'hbe;
	localparam logic [7:0] AllOnes    = 8'hff;
	localparam logic [3:0] PollMark   = 4'd15;

	// Command stages held in the byte counter before the scratchpad read
	localparam logic [3:0] StageSkipConvert = 4'd0;
	localparam logic [3:0] StageConvert     = 4'd1;
	localparam logic [3:0] StageSkipRead    = 4'd2;
	localparam logic [3:0] StageReadPad     = 4'd3;

	// Configuration register indexes
	localparam logic [2:0] RegResetLow    = 3'd0;
	localparam logic [2:0] RegResetWait   = 3'd1;
	localparam logic [2:0] RegShortLow    = 3'd2;
	localparam logic [2:0] RegSampleDelay = 3'd3;
	localparam logic [2:0] RegSlot        = 3'd4;

	// Configuration reset values
	localparam logic [9:0] ResetLowDefault    = 10'd500;
	localparam logic [9:0] ResetWaitDefault   = 10'd500;
	localparam logic [3:0] ShortLowDefault    = 4'd1;
	localparam logic [3:0] SampleDelayDefault = 4'd2;
	localparam logic [7:0] SlotDefault        = 8'd60;

	// One tick's worth of input
	typedef struct packed {
		logic       start_req;
		logic [2:0] sensor;
		logic       line_level;
	} otr_item_t;

	// Queue status towards the sequencer
	typedef struct packed {
		logic      valid;
		otr_item_t item;
	} otr_head_t;

	// Configuration register set
	typedef struct packed {
		logic [9:0] reset_low;
		logic [9:0] reset_wait;
		logic [3:0] short_low;
		logic [3:0] sample_delay;
		logic [7:0] slot;
	} otr_cfg_t;

endpackage
`default_nettype wire

/* src/one_wire_temperature_reader_top.sv */
// Top level of the single-bus temperature reader: queue, sequencer, config registers.
//
//   channel | handshake           | beat carries
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_stall | start_req, sensor, line_level (one 1 us tick)
//   out     | out_valid/out_stall | drive_low, line_select, busy_res, done_res,
//           |                     | temp_whole, temp_half (one per input beat)
//   cfg     | cfg_we              | cfg_index, cfg_wdata (timing registers)
//
// One input beat is taken per cycle while in_stall is low; it is held in the queue and
// its result is then loaded into the output register when the sequencer steps it, once per beat.
// A two-beat queue sits ahead of the sequencer, so the input stalls only once the
// output has been stalled long enough to fill it.
// Reset clears the queue, the sequencer (idle) and loads the default timing registers.
`default_nettype none
module one_wire_temperature_reader_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic       start_req,
	input  wire logic [2:0] sensor,
	input  wire logic       line_level,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       drive_low,
	output      logic [2:0] line_select,
	output      logic       busy_res,
	output      logic       done_res,
	output      logic [6:0] temp_whole,
	output      logic [2:0] temp_half,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [9:0] cfg_wdata
);

	otr_pkg::otr_item_t in_item;
	otr_pkg::otr_head_t head;
	otr_pkg::otr_cfg_t  cfg_q;
	logic               pop;

	assign in_item.start_req  = start_req;
	assign in_item.sensor     = sensor;
	assign in_item.line_level = line_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low    <= otr_pkg::ResetLowDefault;
			cfg_q.reset_wait   <= otr_pkg::ResetWaitDefault;
			cfg_q.short_low    <= otr_pkg::ShortLowDefault;
			cfg_q.sample_delay <= otr_pkg::SampleDelayDefault;
			cfg_q.slot         <= otr_pkg::SlotDefault;
		end else if (cfg_we) begin
			case (cfg_index)
				otr_pkg::RegResetLow:    cfg_q.reset_low    <= cfg_wdata;
				otr_pkg::RegResetWait:   cfg_q.reset_wait   <= cfg_wdata;
				otr_pkg::RegShortLow:    cfg_q.short_low    <= cfg_wdata[3:0];
				otr_pkg::RegSampleDelay: cfg_q.sample_delay <= cfg_wdata[3:0];
				otr_pkg::RegSlot:        cfg_q.slot         <= cfg_wdata[7:0];
				default:                 cfg_q              <= cfg_q;
			endcase
		end
	end

	otr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.head     (head),
		.pop      (pop)
	);

	otr_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_low   (drive_low),
		.line_select (line_select),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.temp_whole  (temp_whole),
		.temp_half   (temp_half)
	);

	// An empty queue never holds off the input
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!head.valid |-> !in_stall)
		else $error("input stalled with an empty queue");

	// Every stepped tick lands in the result register
	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("stepped tick produced no result beat");

	// Temperature fields are zero off the done beat
	a_temp_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> temp_whole == 7'd0 && temp_half == 3'd0)
		else $error("temperature fields set outside the done beat");

	// A done beat is never a busy beat and its half digit is five or zero
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !drive_low
			&& (temp_half == 3'd0 || temp_half == 3'd5))
		else $error("malformed done beat");

endmodule
`default_nettype wire

/* src/otr_queue.sv */
// Front end: accepts tick beats into a short queue ahead of the sequencer.
`default_nettype none
module otr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire otr_pkg::otr_item_t in_item,
	output      otr_pkg::otr_head_t head,
	input  wire logic              pop
);

	otr_pkg::otr_item_t                  slot_q [otr_pkg::QueueDepth];
	logic [otr_pkg::QueuePtrW-1:0]       wr_ptr_q;
	logic [otr_pkg::QueuePtrW-1:0]       rd_ptr_q;
	logic [otr_pkg::QueueCntW-1:0]       count_q;
	logic                                push;
	logic                                do_pop;

	assign in_stall = (count_q == otr_pkg::QueueCntW'(otr_pkg::QueueDepth));
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	function automatic logic [otr_pkg::QueuePtrW-1:0] next_ptr(
		input logic [otr_pkg::QueuePtrW-1:0] p);
		if (p == otr_pkg::QueuePtrW'(otr_pkg::QueueDepth - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/otr_seq.sv */
// Back end: bus sequencer stepped once per tick, with the result register.
`default_nettype none
module otr_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire otr_pkg::otr_cfg_t  cfg,
	input  wire otr_pkg::otr_head_t head,
	output      logic               pop,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic               drive_low,
	output      logic [2:0]         line_select,
	output      logic               busy_res,
	output      logic               done_res,
	output      logic [6:0]         temp_whole,
	output      logic [2:0]         temp_half
);

	localparam logic [3:0] PhIdle    = 4'd0;
	localparam logic [3:0] PhRstLow  = 4'd1;
	localparam logic [3:0] PhRstWait = 4'd2;
	localparam logic [3:0] PhWrLow   = 4'd3;
	localparam logic [3:0] PhWrRec   = 4'd4;
	localparam logic [3:0] PhRdLow   = 4'd5;
	localparam logic [3:0] PhRdRel   = 4'd6;
	localparam logic [3:0] PhRdRec   = 4'd7;
	localparam logic [3:0] PhDone    = 4'd8;

	logic [3:0] phase_q,  phase_nx;
	logic [9:0] tick_q,   tick_nx;
	logic [2:0] bit_q,    bit_nx;
	logic [3:0] byte_q,   byte_nx;
	logic [7:0] shift_q,  shift_nx;
	logic [7:0] first_q,  first_nx;
	logic [2:0] held_q,   held_nx;
	logic       valid_q;

	logic       drive_c, busy_c, done_c;
	logic [6:0] whole_c;
	logic [2:0] half_c;
	logic [9:0] len_c;
	logic [3:0] byte_inc;

	// Span ends on the tick whose count plus one reaches the length; zero acts as one.
	function automatic logic span_over(input logic [9:0] tick, input logic [9:0] len);
		return ({1'b0, tick} + 11'd1) >= {1'b0, len};
	endfunction

	assign pop = head.valid && (!valid_q || !out_stall);

	always_comb begin
		phase_nx = phase_q;
		tick_nx  = tick_q;
		bit_nx   = bit_q;
		byte_nx  = byte_q;
		shift_nx = shift_q;
		first_nx = first_q;
		held_nx  = held_q;
		drive_c  = 1'b0;
		busy_c   = 1'b1;
		done_c   = 1'b0;
		whole_c  = '0;
		half_c   = '0;
		len_c    = '0;
		byte_inc = byte_q + 1'b1;

		case (phase_q)
			PhRstLow: begin
				drive_c = 1'b1;
				if (span_over(tick_q, cfg.reset_low)) begin
					tick_nx  = '0;
					phase_nx = PhRstWait;
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhRstWait: begin
				if (span_over(tick_q, cfg.reset_wait)) begin
					shift_nx = otr_pkg::CmdSkip;
					bit_nx   = '0;
					tick_nx  = '0;
					phase_nx = PhWrLow;
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhWrLow: begin
				drive_c = 1'b1;
				len_c   = shift_q[0] ? {6'd0, cfg.short_low} : {2'd0, cfg.slot};
				if (span_over(tick_q, len_c)) begin
					tick_nx  = '0;
					phase_nx = PhWrRec;
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhWrRec: begin
				len_c = shift_q[0] ? {2'd0, cfg.slot} : 10'd1;
				if (span_over(tick_q, len_c)) begin
					shift_nx = {1'b0, shift_q[7:1]};
					tick_nx  = '0;
					phase_nx = PhWrLow;
					if (bit_q == 3'd7) begin
						bit_nx = '0;
						// Command chain: skip, convert, poll / skip, read pad, read
						case (byte_q)
							otr_pkg::StageSkipConvert: begin
								byte_nx  = otr_pkg::StageConvert;
								shift_nx = otr_pkg::CmdConvert;
							end
							otr_pkg::StageConvert: begin
								byte_nx  = otr_pkg::PollMark;
								phase_nx = PhRdLow;
							end
							otr_pkg::StageSkipRead: begin
								byte_nx  = otr_pkg::StageReadPad;
								shift_nx = otr_pkg::CmdReadPad;
							end
							default: begin
								byte_nx  = 4'd0;
								phase_nx = PhRdLow;
							end
						endcase
					end else begin
						bit_nx = bit_q + 1'b1;
					end
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhRdLow: begin
				drive_c = 1'b1;
				if (span_over(tick_q, {6'd0, cfg.short_low})) begin
					tick_nx  = '0;
					phase_nx = PhRdRel;
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhRdRel: begin
				if (tick_q >= {6'd0, cfg.sample_delay}) begin
					shift_nx = {head.item.line_level, shift_q[7:1]};
					tick_nx  = '0;
					phase_nx = PhRdRec;
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhRdRec: begin
				if (span_over(tick_q, {2'd0, cfg.slot})) begin
					tick_nx  = '0;
					phase_nx = PhRdLow;
					if (bit_q == 3'd7) begin
						bit_nx = '0;
						if (byte_q == otr_pkg::PollMark) begin
							// Converter busy reads as all ones: keep polling
							if (shift_q != otr_pkg::AllOnes) begin
								byte_nx  = otr_pkg::StageSkipRead;
								phase_nx = PhRstLow;
							end
						end else begin
							if (byte_q == 4'd0) begin
								first_nx = shift_q;
							end
							byte_nx = byte_inc;
							if (byte_inc >= 4'(otr_pkg::ScratchpadBytes)) begin
								phase_nx = PhDone;
							end
						end
					end else begin
						bit_nx = bit_q + 1'b1;
					end
				end else begin
					tick_nx = tick_q + 1'b1;
				end
			end
			PhDone: begin
				busy_c   = 1'b0;
				done_c   = 1'b1;
				whole_c  = first_q[7:1];
				half_c   = first_q[0] ? 3'd5 : 3'd0;
				phase_nx = PhIdle;
				tick_nx  = '0;
			end
			default: begin
				busy_c = 1'b0;
				if (head.item.start_req) begin
					held_nx  = 3'(head.item.sensor % otr_pkg::NumLines);
					byte_nx  = '0;
					bit_nx   = '0;
					tick_nx  = '0;
					phase_nx = PhRstLow;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			first_q <= '0;
			held_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_nx;
				tick_q  <= tick_nx;
				bit_q   <= bit_nx;
				byte_q  <= byte_nx;
				shift_q <= shift_nx;
				first_q <= first_nx;
				held_q  <= held_nx;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result register: hold while stalled, load with the tick just stepped
	always_ff @(posedge clk) begin
		if (pop) begin
			drive_low   <= drive_c;
			line_select <= held_nx;
			busy_res    <= busy_c;
			done_res    <= done_c;
			temp_whole  <= whole_c;
			temp_half   <= half_c;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for the single-bus temperature reader: tick stimulus, predictor, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit    = 100000;
	localparam int DrainLimit    = 2000;
	localparam int HoldOffCycles = 40;
	localparam int ZeroCfgRow    = 6;
	localparam int MaxPrinted    = 30;

	localparam logic [2:0] HalfDigit = 3'd5;

	// Predictor phase codes
	localparam logic [3:0] SeqIdle    = 4'd0;
	localparam logic [3:0] SeqRstLow  = 4'd1;
	localparam logic [3:0] SeqRstWait = 4'd2;
	localparam logic [3:0] SeqWrLow   = 4'd3;
	localparam logic [3:0] SeqWrRec   = 4'd4;
	localparam logic [3:0] SeqRdLow   = 4'd5;
	localparam logic [3:0] SeqRdRel   = 4'd6;
	localparam logic [3:0] SeqRdRec   = 4'd7;
	localparam logic [3:0] SeqDone    = 4'd8;

	typedef struct packed {
		logic       drive;
		logic [2:0] line;
		logic       busy;
		logic       done;
		logic [6:0] whole;
		logic [2:0] half;
	} bus_out_t;

	typedef struct packed {
		otr_pkg::otr_item_t it;
		logic               typed;
		bus_out_t           want;
	} dir_row_t;

	localparam otr_pkg::otr_cfg_t MaxTiming  = '{10'h3ff, 10'h3ff, 4'hf, 4'hf, 8'hff};
	localparam otr_pkg::otr_cfg_t ZeroTiming = '{10'd0, 10'd0, 4'd0, 4'd0, 8'd0};

	// Opening rows run on the reset timing; from ZeroCfgRow on every length register is zero
	localparam dir_row_t DirRows [24] = '{
		'{'{1'b0, 3'd5, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 7'd0, 3'd0}},
		'{'{1'b0, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 7'd0, 3'd0}},
		'{'{1'b0, 3'd7, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 7'd0, 3'd0}},
		'{'{1'b1, 3'd7, 1'b0}, 1'b1, '{1'b0, 3'd7, 1'b0, 1'b0, 7'd0, 3'd0}},
		'{'{1'b1, 3'd2, 1'b1}, 1'b1, '{1'b1, 3'd7, 1'b1, 1'b0, 7'd0, 3'd0}},
		'{'{1'b0, 3'd0, 1'b0}, 1'b1, '{1'b1, 3'd7, 1'b1, 1'b0, 7'd0, 3'd0}},
		'{'{1'b0, 3'd0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd7, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd5, 1'b1}, 1'b0, '0},
		'{'{1'b0, 3'd2, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd7, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd1, 1'b1}, 1'b0, '0},
		'{'{1'b0, 3'd6, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd3, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd4, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd7, 1'b1}, 1'b0, '0},
		'{'{1'b0, 3'd7, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 3'd1, 1'b0}, 1'b0, '0},
		'{'{1'b0, 3'd2, 1'b1}, 1'b0, '0},
		'{'{1'b0, 3'd3, 1'b0}, 1'b0, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       start_req;
	logic [2:0] sensor;
	logic       line_level;
	logic       out_valid;
	logic       out_stall;
	logic       drive_low;
	logic [2:0] line_select;
	logic       busy_res;
	logic       done_res;
	logic [6:0] temp_whole;
	logic [2:0] temp_half;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [9:0] cfg_wdata;

	// Shadow of the offered beat: a typed-in expectation replaces the prediction
	logic     beat_typed;
	bus_out_t beat_want;

	bit idle_on;
	bit hold_off_req;
	int mismatches;
	int out_beats;
	int cycle_count;

	bus_out_t pending_outs [$];

	// Predictor state
	otr_pkg::otr_cfg_t timing;
	logic [3:0]        ph;
	int unsigned       ticks;
	logic [2:0]        bit_no;
	logic [3:0]        byte_no;
	logic [7:0]        shreg;
	logic [7:0]        byte0;
	logic [2:0]        line_q;

	one_wire_temperature_reader_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_req   (start_req),
		.sensor      (sensor),
		.line_level  (line_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_low   (drive_low),
		.line_select (line_select),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.temp_whole  (temp_whole),
		.temp_half   (temp_half),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// A zero length behaves as one
	function automatic bit span_done(int unsigned len);
		return ticks + 1 >= len;
	endfunction

	function automatic void start_write(logic [7:0] cmd);
		shreg  = cmd;
		bit_no = '0;
		ticks  = 0;
		ph     = SeqWrLow;
	endfunction

	function automatic void start_read();
		bit_no = '0;
		ticks  = 0;
		ph     = SeqRdLow;
	endfunction

	function automatic void start_reset();
		ticks = 0;
		ph    = SeqRstLow;
	endfunction

	// Advance the bus sequencer by one tick; outputs reflect the phase at entry
	function automatic bus_out_t step_reader(otr_pkg::otr_item_t it);
		bus_out_t o;
		logic     lsb;
		o      = '0;
		o.busy = 1'b1;
		lsb    = shreg[0];
		case (ph)
			SeqRstLow: begin
				o.drive = 1'b1;
				if (span_done(timing.reset_low)) begin
					ticks = 0;
					ph    = SeqRstWait;
				end else ticks++;
			end
			SeqRstWait: begin
				if (span_done(timing.reset_wait)) start_write(otr_pkg::CmdSkip);
				else ticks++;
			end
			SeqWrLow: begin
				o.drive = 1'b1;
				if (span_done(lsb ? timing.short_low : timing.slot)) begin
					ticks = 0;
					ph    = SeqWrRec;
				end else ticks++;
			end
			SeqWrRec: begin
				if (span_done(lsb ? timing.slot : 1)) begin
					shreg = shreg >> 1;
					ticks = 0;
					ph    = SeqWrLow;
					if (bit_no == 3'd7) begin
						case (byte_no)
							otr_pkg::StageSkipConvert: begin
								byte_no = otr_pkg::StageConvert;
								start_write(otr_pkg::CmdConvert);
							end
							otr_pkg::StageConvert: begin
								byte_no = otr_pkg::PollMark;
								start_read();
							end
							otr_pkg::StageSkipRead: begin
								byte_no = otr_pkg::StageReadPad;
								start_write(otr_pkg::CmdReadPad);
							end
							default: begin
								byte_no = '0;
								start_read();
							end
						endcase
					end else bit_no++;
				end else ticks++;
			end
			SeqRdLow: begin
				o.drive = 1'b1;
				if (span_done(timing.short_low)) begin
					ticks = 0;
					ph    = SeqRdRel;
				end else ticks++;
			end
			SeqRdRel: begin
				if (ticks >= timing.sample_delay) begin
					shreg = {it.line_level, shreg[7:1]};
					ticks = 0;
					ph    = SeqRdRec;
				end else ticks++;
			end
			SeqRdRec: begin
				if (span_done(timing.slot)) begin
					ticks = 0;
					ph    = SeqRdLow;
					if (bit_no != 3'd7) bit_no++;
					else if (byte_no == otr_pkg::PollMark) begin
						// keep polling while the converter answers all ones
						if (shreg != otr_pkg::AllOnes) begin
							byte_no = otr_pkg::StageSkipRead;
							start_reset();
						end else start_read();
					end else begin
						if (byte_no == 4'd0) byte0 = shreg;
						byte_no = byte_no + 4'd1;
						if (byte_no >= otr_pkg::ScratchpadBytes) begin
							ticks = 0;
							ph    = SeqDone;
						end else start_read();
					end
				end else ticks++;
			end
			SeqDone: begin
				o.busy  = 1'b0;
				o.done  = 1'b1;
				o.whole = byte0[7:1];
				o.half  = byte0[0] ? HalfDigit : 3'd0;
				ph      = SeqIdle;
				ticks   = 0;
			end
			default: begin
				o.busy = 1'b0;
				if (it.start_req) begin
					line_q  = 3'(it.sensor % otr_pkg::NumLines);
					byte_no = '0;
					bit_no  = '0;
					start_reset();
				end
			end
		endcase
		o.line = line_q;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= MaxPrinted)
			$display("mismatch %s: got %0d want %0d (output beat %0d)", what, got, want, out_beats);
	endtask

	task automatic check_fields(bus_out_t got, bus_out_t want);
		if (got.drive !== want.drive) report_mismatch("drive_low", got.drive, want.drive);
		if (got.line !== want.line) report_mismatch("line_select", got.line, want.line);
		if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
		if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
		if (got.whole !== want.whole) report_mismatch("temp_whole", got.whole, want.whole);
		if (got.half !== want.half) report_mismatch("temp_half", got.half, want.half);
	endtask

	// Offer one tick after a random gap and hold it until taken
	task automatic send_tick(otr_pkg::otr_item_t it, logic typed, bus_out_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid                          <= 1'b1;
		{start_req, sensor, line_level}   <= it;
		beat_typed                        <= typed;
		beat_want                         <= want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		for (int w = 0; w < DrainLimit && pending_outs.size() != 0; w++) @(negedge clk);
	endtask

	task automatic apply_timing(otr_pkg::otr_cfg_t c);
		logic [2:0] regs [5];
		logic [9:0] vals [5];
		regs = '{otr_pkg::RegResetLow, otr_pkg::RegResetWait, otr_pkg::RegShortLow,
			otr_pkg::RegSampleDelay, otr_pkg::RegSlot};
		vals = '{c.reset_low, c.reset_wait, 10'(c.short_low), 10'(c.sample_delay),
			10'(c.slot)};
		for (int r = 0; r < 5; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[r];
			cfg_wdata <= vals[r];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		timing = c;
	endtask

	// Short slots so that whole read sequences fit in the run
	function automatic otr_pkg::otr_cfg_t tiny_timing();
		otr_pkg::otr_cfg_t c;
		c.reset_low    = 10'($urandom_range(0, 2));
		c.reset_wait   = 10'($urandom_range(0, 2));
		c.short_low    = 4'($urandom_range(0, 1));
		c.sample_delay = 4'($urandom_range(0, 1));
		c.slot         = 8'($urandom_range(0, 2));
		return c;
	endfunction

	function automatic otr_pkg::otr_item_t rand_tick(int level_bias);
		otr_pkg::otr_item_t it;
		it.start_req  = 1'($urandom_range(0, 1));
		it.sensor     = 3'($urandom_range(0, 7));
		it.line_level = ($urandom_range(0, 99) < level_bias);
		return it;
	endfunction

	always @(posedge clk) begin
		bus_out_t predicted;
		if (arst_n && in_valid && !in_stall) begin
			predicted = step_reader({start_req, sensor, line_level});
			pending_outs.push_back(beat_typed ? beat_want : predicted);
		end
	end

	always @(posedge clk) begin
		bus_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outs.size() == 0) report_mismatch("beat with nothing pending", 1, 0);
			else begin
				want = pending_outs.pop_front();
				check_fields({drive_low, line_select, busy_res, done_res, temp_whole, temp_half},
					want);
			end
			out_beats++;
		end
	end

	// Receiver: random stalls per beat, plus one long hold-off on request
	initial begin
		int k;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HoldOffCycles) @(negedge clk);
			end
			k = idle_on ? $urandom_range(0, 3) : 0;
			if (k != 0) begin
				out_stall <= 1'b1;
				repeat (k) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int bias;
		int count;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		start_req    = 1'b0;
		sensor       = '0;
		line_level   = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		beat_typed   = 1'b0;
		beat_want    = '0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		mismatches   = 0;
		out_beats    = 0;
		timing       = '{otr_pkg::ResetLowDefault, otr_pkg::ResetWaitDefault,
			otr_pkg::ShortLowDefault, otr_pkg::SampleDelayDefault, otr_pkg::SlotDefault};
		ph           = SeqIdle;
		ticks        = 0;
		bit_no       = '0;
		byte_no      = '0;
		shreg        = '0;
		byte0        = '0;
		line_q       = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < $size(DirRows); r++) begin
			if (r == ZeroCfgRow) begin
				settle();
				apply_timing(ZeroTiming);
			end
			send_tick(DirRows[r].it, DirRows[r].typed, DirRows[r].want);
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			apply_timing(p == 0 ? MaxTiming : tiny_timing());
			case ($urandom_range(0, 2))
				0: bias = 50;
				1: bias = 90;
				default: bias = 97;
			endcase
			count = (p == 0) ? 60 : 288;
			for (int n = 0; n < count; n++) begin
				if (n % 96 == 0) idle_on = ($urandom_range(0, 3) != 0);
				// hold the output back long enough to back the queue up into the input
				if (p == 1 && n == 60) hold_off_req = 1'b1;
				send_tick(rand_tick(bias), 1'b0, '0);
			end
		end

		settle();
		repeat (4) @(negedge clk);
		if (pending_outs.size() != 0)
			report_mismatch("beats never delivered", 0, pending_outs.size());
		if (mismatches == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
